>>> rtl/rbd_pkg.sv
`default_nettype none

package rbd_pkg;

  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned SUM_W      = CH_W + 1;
  localparam int unsigned TOTAL_W    = SUM_W + 1;
  localparam int unsigned PIX_W      = NUM_CH * CH_W;
  localparam int unsigned ROW_SUMS_W = NUM_CH * SUM_W;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(128);

  typedef enum logic [0:0] {
    REG_HALF_WIDTH  = 1'b0,
    REG_HALF_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              wr;
    logic [SIZE_W-1:0] half_width;
    logic [SIZE_W-1:0] half_height;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/rbd_cfg.sv
`default_nettype none

module rbd_cfg
  import rbd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  logic [SIZE_W-1:0] half_width_q;
  logic [SIZE_W-1:0] half_height_q;
  logic              wr_en;
  reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= SIZE_RESET;
      half_height_q <= SIZE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HALF_WIDTH:  half_width_q  <= pwdata[SIZE_W-1:0];
        REG_HALF_HEIGHT: half_height_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HALF_WIDTH:  prdata = APB_DATA_W'(half_width_q);
      REG_HALF_HEIGHT: prdata = APB_DATA_W'(half_height_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.wr          = wr_en;
  assign cfg_o.half_width  = half_width_q;
  assign cfg_o.half_height = half_height_q;

endmodule

`default_nettype wire

>>> rtl/rbd_linebuf.sv
`default_nettype none

module rbd_linebuf
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [ROW_SUMS_W-1:0] wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic      [ROW_SUMS_W-1:0] rdata_o
);

  logic [ROW_SUMS_W-1:0] mem [DEPTH];
  logic [ROW_SUMS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/rgba_box_downsample_2x2.sv
// 2x2 box-filter downsampler for RGBA8 images.
// Source pixels enter on the s_axis stream in raster order, one per request,
// red in the low byte. The source frame is (2*half_width) x (2*half_height),
// both set over the APB port (0x0 half_width, 0x4 half_height; 0 is used as 1,
// values above the maximum are clamped). Any register write restarts the frame
// position; write only while the block is idle.
// Even source rows store each pixel pair's channel sums in a line buffer of
// MAX_HALF_WIDTH entries. On odd rows each second pixel of a pair completes a
// 2x2 block; its truncated mean leaves on m_axis in the cycle after that pixel
// is accepted, with tlast set on the last block of the frame.
// Throughput is one source pixel per clock while no held result stalls input; the
// line buffer has one write and one registered read port, and the read is issued
// on the first pixel of a pair in an odd row. A single output register holds a
// result while m_axis_tready is low; only pixels that would produce a new result
// are then held back, the others are still accepted. Reset clears the position,
// the pair register and the output valid, and sets both sizes to 128. The line buffer is not cleared.
`default_nettype none

module rgba_box_downsample_2x2
  import rbd_pkg::*;
#(
  parameter int unsigned MAX_HALF_WIDTH  = 1024,
  parameter int unsigned MAX_HALF_HEIGHT = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  input  wire logic [PIX_W-1:0]      s_axis_tdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  output logic      [PIX_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic                       m_axis_tlast,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned IW = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
  localparam int unsigned HW = (MAX_HALF_HEIGHT > 1) ? $clog2(MAX_HALF_HEIGHT) : 1;

  cfg_t cfg;

  logic [IW-1:0]         wm1;
  logic [HW-1:0]         hm1;
  logic [IW:0]           col_q;
  logic [HW:0]           row_q;
  logic                  col_last;
  logic                  row_last;
  logic                  second_pix;
  logic                  odd_row;
  logic                  produces;
  logic                  in_acc;
  logic [PIX_W-1:0]      pair_first_q;
  logic [ROW_SUMS_W-1:0] pair_sums;
  logic [ROW_SUMS_W-1:0] above_sums;
  logic [PIX_W-1:0]      mean_pix;
  logic                  buf_we;
  logic                  buf_re;
  logic                  out_valid_q;
  logic [PIX_W-1:0]      out_data_q;
  logic                  out_last_q;

  rbd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    if (cfg.half_width == '0) begin
      wm1 = '0;
    end else if (32'(cfg.half_width) > MAX_HALF_WIDTH) begin
      wm1 = IW'(MAX_HALF_WIDTH - 1);
    end else begin
      wm1 = IW'(cfg.half_width - 1'b1);
    end
    if (cfg.half_height == '0) begin
      hm1 = '0;
    end else if (32'(cfg.half_height) > MAX_HALF_HEIGHT) begin
      hm1 = HW'(MAX_HALF_HEIGHT - 1);
    end else begin
      hm1 = HW'(cfg.half_height - 1'b1);
    end
  end

  assign second_pix = col_q[0];
  assign odd_row    = row_q[0];
  assign col_last   = second_pix && (col_q[IW:1] == wm1);
  assign row_last   = odd_row && (row_q[HW:1] == hm1);
  assign produces   = second_pix && odd_row;

  assign s_axis_tready = !out_valid_q || m_axis_tready || !produces;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg.wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_first_q <= '0;
    end else if (in_acc && !second_pix) begin
      pair_first_q <= s_axis_tdata;
    end
  end

  always_comb begin
    logic [SUM_W-1:0]   s;
    logic [TOTAL_W-1:0] t;
    for (int i = 0; i < NUM_CH; i++) begin
      s = SUM_W'(pair_first_q[i*CH_W +: CH_W]) + SUM_W'(s_axis_tdata[i*CH_W +: CH_W]);
      t = TOTAL_W'(above_sums[i*SUM_W +: SUM_W]) + TOTAL_W'(s);
      pair_sums[i*SUM_W +: SUM_W] = s;
      mean_pix[i*CH_W +: CH_W]    = t[TOTAL_W-1:2];
    end
  end

  assign buf_we = in_acc && second_pix && !odd_row;
  assign buf_re = in_acc && !second_pix && odd_row;

  rbd_linebuf #(
    .DEPTH (MAX_HALF_WIDTH),
    .AW    (IW)
  ) u_linebuf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (col_q[IW:1]),
    .wdata_i (pair_sums),
    .re_i    (buf_re),
    .raddr_i (col_q[IW:1]),
    .rdata_o (above_sums)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && produces) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && produces) begin
      out_data_q <= mean_pix;
      out_last_q <= col_last && row_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
